// ----- src/pcnd_pkg.sv -----
// ----------------------------------------------------------------------------
// pcnd_pkg: shared types and constants of the prefix-coded number decoder
// Byte classes, status codes, decoder phases and the queue entry format.
// ----------------------------------------------------------------------------
package pcnd_pkg;

  // Byte codes with a special meaning in the stream.
  localparam logic [7:0] BYTE_PREFIX = 8'd255;
  localparam logic [7:0] BYTE_EIGHT  = 8'd254;
  localparam logic [7:0] BYTE_LEN4   = 8'd253;
  localparam logic [7:0] BYTE_LEN2   = 8'd252;
  localparam logic [7:0] BYTE_LEN1   = 8'd251;

  // Class of one incoming transaction, decided without context.
  typedef enum logic [2:0] {
    KIND_LIT,
    KIND_LEN1,
    KIND_LEN2,
    KIND_LEN4,
    KIND_EIGHT,
    KIND_PREFIX,
    KIND_END
  } kind_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REPEAT = 2'd1,
    ST_EIGHT  = 2'd2,
    ST_ENDED  = 2'd3
  } status_e;

  // Decoder phases.
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_MARKER = 2'd1,
    PH_DATA   = 2'd2
  } phase_e;

  // One classified byte as it travels through the queue.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
  } item_t;

  // A queue port: valid flag plus entry.
  typedef struct packed {
    logic  valid;
    item_t item;
  } qport_t;

  // Event produced by the back end for one consumed byte.
  typedef struct packed {
    logic        emit;
    logic        ok;
    status_e     status;
    logic [31:0] value;
  } event_t;

endpackage

// ----- src/pcnd_if.sv -----
// ----------------------------------------------------------------------------
// pcnd_if: stream channels of the prefix-coded number decoder
// Byte input channel and decoded number output channel, valid/ready.
// ----------------------------------------------------------------------------
interface pcnd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface pcnd_num_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] number_value;
  logic        [1:0]  status;

  modport source (output valid, output number_value, output status, input ready);
  modport sink   (input valid, input number_value, input status, output ready);
endinterface

// ----- src/pcnd_front.sv -----
// ----------------------------------------------------------------------------
// pcnd_front: input acceptance and byte classification
// Accepts byte transactions while the queue has room and tags each byte.
// ----------------------------------------------------------------------------
module pcnd_front (
  pcnd_byte_if.sink       in_i,
  input  logic            q_ready_i,
  output pcnd_pkg::qport_t push_o
);
  import pcnd_pkg::*;

  kind_e kind;

  // Classify the byte; end of input overrides the byte value.
  always_comb begin
    if (in_i.end_of_input) begin
      kind = KIND_END;
    end else begin
      case (in_i.data_byte)
        BYTE_PREFIX: kind = KIND_PREFIX;
        BYTE_EIGHT:  kind = KIND_EIGHT;
        BYTE_LEN4:   kind = KIND_LEN4;
        BYTE_LEN2:   kind = KIND_LEN2;
        BYTE_LEN1:   kind = KIND_LEN1;
        default:     kind = KIND_LIT;
      endcase
    end
  end

  // Hand the transaction to the queue when it has room.
  assign in_i.ready             = q_ready_i;
  assign push_o.valid           = in_i.valid && q_ready_i;
  assign push_o.item.kind       = kind;
  assign push_o.item.data_byte  = in_i.data_byte;

endmodule

// ----- src/pcnd_queue.sv -----
// ----------------------------------------------------------------------------
// pcnd_queue: small FIFO between the front and back ends
// Holds classified bytes; per cycle one push if not full, one pop if not empty.
// ----------------------------------------------------------------------------
module pcnd_queue #(
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pcnd_pkg::qport_t push_i,
  output logic             ready_o,
  output pcnd_pkg::qport_t head_o,
  input  logic             pop_i
);
  import pcnd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_pop;

  assign ready_o      = (count_q != FullCnt);
  assign head_o.valid = (count_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_o.valid;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i.valid) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i.valid && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i.valid && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

endmodule

// ----- src/pcnd_back.sv -----
// ----------------------------------------------------------------------------
// pcnd_back: decoding state machine and result register
// Consumes classified bytes, gathers data bytes and emits decoded numbers.
// ----------------------------------------------------------------------------
module pcnd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pcnd_pkg::qport_t head_i,
  output logic             pop_o,
  pcnd_num_if.source       out_o
);
  import pcnd_pkg::*;

  phase_e      phase_q, phase_d;
  logic        invert_q, invert_d;
  logic [2:0]  left_q, left_d;
  logic [1:0]  pos_q, pos_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] acc_merged;
  event_t      ev;

  logic               res_valid_q, res_valid_d;
  logic signed [31:0] res_value_q, res_value_d;
  logic        [1:0]  res_status_q, res_status_d;

  // A byte is consumed whenever the result slot is free or being drained.
  assign pop_o = head_i.valid && (!res_valid_q || out_o.ready);

  // Accumulator with the incoming data byte placed at its position.
  always_comb begin
    acc_merged = acc_q;
    case (pos_q)
      2'd0:    acc_merged[7:0]   = head_i.item.data_byte;
      2'd1:    acc_merged[15:8]  = head_i.item.data_byte;
      2'd2:    acc_merged[23:16] = head_i.item.data_byte;
      default: acc_merged[31:24] = head_i.item.data_byte;
    endcase
  end

  // Next state of the decoder and the event for this byte.
  always_comb begin
    phase_d   = phase_q;
    invert_d  = invert_q;
    left_d    = left_q;
    pos_d     = pos_q;
    acc_d     = acc_q;
    ev.emit   = 1'b0;
    ev.ok     = 1'b0;
    ev.status = ST_OK;
    ev.value  = '0;
    if (pop_o) begin
      if (head_i.item.kind == KIND_END) begin
        ev.emit   = 1'b1;
        ev.status = ST_ENDED;
      end else begin
        unique case (phase_q)
          PH_DATA: begin
            acc_d  = acc_merged;
            pos_d  = pos_q + 2'd1;
            left_d = left_q - 3'd1;
            if (left_q == 3'd1) begin
              ev.emit  = 1'b1;
              ev.ok    = 1'b1;
              ev.value = acc_merged;
            end
          end
          default: begin
            if (head_i.item.kind == KIND_PREFIX) begin
              if (phase_q == PH_MARKER) begin
                ev.emit   = 1'b1;
                ev.status = ST_REPEAT;
              end else begin
                invert_d = 1'b1;
                phase_d  = PH_MARKER;
              end
            end else begin
              // Length marker or literal value.
              unique case (head_i.item.kind)
                KIND_EIGHT: begin
                  ev.emit   = 1'b1;
                  ev.status = ST_EIGHT;
                end
                KIND_LEN4, KIND_LEN2, KIND_LEN1: begin
                  phase_d = PH_DATA;
                  pos_d   = 2'd0;
                  acc_d   = '0;
                  case (head_i.item.kind)
                    KIND_LEN4: left_d = 3'd4;
                    KIND_LEN2: left_d = 3'd2;
                    default:   left_d = 3'd1;
                  endcase
                end
                default: begin
                  ev.emit  = 1'b1;
                  ev.ok    = 1'b1;
                  ev.value = {24'd0, head_i.item.data_byte};
                end
              endcase
            end
          end
        endcase
      end
      // Every result returns the decoder to its initial state.
      if (ev.emit) begin
        phase_d  = PH_FIRST;
        invert_d = 1'b0;
        left_d   = '0;
        pos_d    = '0;
        acc_d    = '0;
      end
    end
  end

  // Result register contents.
  always_comb begin
    res_valid_d  = res_valid_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    if (out_o.ready) begin
      res_valid_d = 1'b0;
    end
    if (ev.emit) begin
      res_valid_d  = 1'b1;
      res_status_d = ev.status;
      if (ev.ok && invert_q) begin
        res_value_d = ~ev.value;
      end else begin
        res_value_d = ev.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FIRST;
      invert_q    <= 1'b0;
      left_q      <= '0;
      pos_q       <= '0;
      acc_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      invert_q    <= invert_d;
      left_q      <= left_d;
      pos_q       <= pos_d;
      acc_q       <= acc_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
  end

  assign out_o.valid        = res_valid_q;
  assign out_o.number_value = res_value_q;
  assign out_o.status       = res_status_q;

endmodule

// ----- src/prefix_coded_number_decoder_core.sv -----
// ----------------------------------------------------------------------------
// prefix_coded_number_decoder_core: prefix-coded integer stream decoder
// Decodes optionally inverted, length-prefixed little-endian integers.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Fields                      Meaning
//  in_i     in   data_byte, end_of_input     one stream byte per transaction
//  out_o    out  number_value, status        one decoded number or error
//
// One byte is accepted per cycle while the queue has room; a number's last
// byte passes the queue, then the result register. Sustained rate is one byte
// per cycle while results are taken, set by the back end consuming one queue
// entry per cycle. The input keeps accepting while a result waits, up to
// QueueDepth bytes. Reset clears the queue and the decoder state.
//
module prefix_coded_number_decoder_core #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pcnd_byte_if.sink   in_i,
  pcnd_num_if.source  out_o
);
  import pcnd_pkg::*;

  qport_t push;
  qport_t head;
  logic   q_ready;
  logic   pop;

  // Front end: accept and classify.
  pcnd_front u_front (
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .push_o    (push)
  );

  // Queue between front and back ends.
  pcnd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (q_ready),
    .head_o  (head),
    .pop_i   (pop)
  );

  // Back end: decode and deliver results.
  pcnd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench of the prefix-coded number decoder core
// Drives byte streams (directed, then random numbers, errors and broken
// sequences) with random idling on both channels, predicts every decoded
// number in a scoreboard and checks each output transaction against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import pcnd_pkg::*;

  localparam int ItemTarget = 1050;
  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 120;

  // One decoded number as the decoder should deliver it.
  typedef struct {
    logic [31:0] value;
    status_e     status;
  } number_t;

  // One byte of the stream together with its end-of-input flag.
  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
  } stream_byte_t;

  // Tracks the decoder state and holds the numbers still to come out.
  class number_scoreboard;
    phase_e      stage;
    logic        negate;
    logic [2:0]  remaining;
    logic [1:0]  lane;
    logic [31:0] gathered;
    number_t     due_q[$];
    int          errors;

    function new();
      stage     = PH_FIRST;
      negate    = 1'b0;
      remaining = '0;
      lane      = '0;
      gathered  = '0;
      errors    = 0;
    endfunction

    // Queues one number and starts over on a fresh one.
    function void push(logic [31:0] value, status_e status);
      number_t n;
      n.value  = value;
      n.status = status;
      due_q.push_back(n);
      stage     = PH_FIRST;
      negate    = 1'b0;
      remaining = '0;
      lane      = '0;
      gathered  = '0;
    endfunction

    // Handles the length marker, or a literal value below the markers.
    function void take_length(logic [7:0] b);
      logic [31:0] lit;
      lit = {24'd0, b};
      case (b)
        BYTE_EIGHT: push(32'd0, ST_EIGHT);
        BYTE_LEN4:  remaining = 3'd4;
        BYTE_LEN2:  remaining = 3'd2;
        BYTE_LEN1:  remaining = 3'd1;
        default:    push(negate ? ~lit : lit, ST_OK);
      endcase
      if (b == BYTE_LEN4 || b == BYTE_LEN2 || b == BYTE_LEN1) begin
        stage    = PH_DATA;
        lane     = '0;
        gathered = '0;
      end
    endfunction

    // Advances the prediction by one accepted input transaction.
    function void note_byte(logic [7:0] b, logic eoi);
      if (eoi) begin
        push(32'd0, ST_ENDED);
      end else begin
        case (stage)
          PH_MARKER: begin
            if (b == BYTE_PREFIX) push(32'd0, ST_REPEAT);
            else take_length(b);
          end
          PH_DATA: begin
            gathered  = gathered | ({24'd0, b} << {lane, 3'b000});
            lane      = lane + 2'd1;
            remaining = remaining - 3'd1;
            if (remaining == 3'd0) push(negate ? ~gathered : gathered, ST_OK);
          end
          default: begin
            if (b == BYTE_PREFIX) begin
              negate = 1'b1;
              stage  = PH_MARKER;
            end else begin
              take_length(b);
            end
          end
        endcase
      end
    endfunction

    // Compares one output transaction with the oldest predicted number.
    function void check_number(logic [31:0] value, logic [1:0] status);
      number_t n;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got value %h status %0d",
                 $time, value, status);
      end else begin
        n = due_q.pop_front();
        if (value !== n.value) begin
          errors++;
          $display("%0t: number_value expected %h, got %h", $time, n.value, value);
        end
        if (status !== n.status) begin
          errors++;
          $display("%0t: status expected %0d, got %0d", $time, n.status, status);
        end
      end
    endfunction

    function int outstanding();
      return due_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  pcnd_byte_if in_if ();
  pcnd_num_if  out_if ();

  prefix_coded_number_decoder_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  number_scoreboard sb = new();

  stream_byte_t tx_q[$];
  int           sent_count  = 0;
  int           cycle_count = 0;
  bit           steady      = 1'b0;
  bit           hold_req    = 1'b0;

  // Clock: 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Mostly random bytes, with the all-zero and all-one values now and then.
  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hff;
    return 8'($urandom);
  endfunction

  // Appends one random encoding, sometimes an error or a broken one.
  function automatic void append_number();
    stream_byte_t seq[$];
    stream_byte_t sb_item;
    int           r;
    int           n_data;
    int           pos;
    n_data = 0;
    sb_item.eoi = 1'b0;
    r = $urandom_range(99);
    if (r < 96 && $urandom_range(1) == 1) begin
      sb_item.data = BYTE_PREFIX;
      seq.push_back(sb_item);
    end
    if (r < 25) begin
      sb_item.data = 8'($urandom_range(250));
      seq.push_back(sb_item);
    end else if (r < 45) begin
      sb_item.data = BYTE_LEN1;
      n_data = 1;
    end else if (r < 65) begin
      sb_item.data = BYTE_LEN2;
      n_data = 2;
    end else if (r < 87) begin
      sb_item.data = BYTE_LEN4;
      n_data = 4;
    end else if (r < 92) begin
      sb_item.data = BYTE_EIGHT;
    end else if (r < 96) begin
      // Repeated prefix: force the leading 255 if it was not drawn.
      if (seq.size() == 0) begin
        sb_item.data = BYTE_PREFIX;
        seq.push_back(sb_item);
      end
      sb_item.data = BYTE_PREFIX;
    end else begin
      sb_item.data = 8'($urandom);
    end
    if (r >= 25) seq.push_back(sb_item);
    for (int i = 0; i < n_data; i++) begin
      sb_item.data = rand_byte();
      seq.push_back(sb_item);
    end
    // Break the sequence with an end of input at a random place.
    if ($urandom_range(99) < 6) begin
      pos = $urandom_range(seq.size() - 1);
      seq[pos].eoi  = 1'b1;
      seq[pos].data = 8'($urandom);
    end
    if ($urandom_range(99) < 3) begin
      sb_item.eoi  = 1'b1;
      sb_item.data = 8'($urandom);
      seq.push_back(sb_item);
    end
    foreach (seq[i]) tx_q.push_back(seq[i]);
  endfunction

  // Offers one byte transaction and waits until it is accepted.
  task automatic send_item(input logic [7:0] b, input logic e);
    in_if.valid        <= 1'b1;
    in_if.data_byte    <= b;
    in_if.end_of_input <= e;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_byte(b, e);
    sent_count++;
    // Idle cycles are drawn one at a time, each further one with a 31 percent chance.
    while (!steady && $urandom_range(99) < 31) begin
      in_if.valid        <= 1'b0;
      in_if.data_byte    <= 8'($urandom);
      in_if.end_of_input <= 1'($urandom);
      @(posedge clk_i);
    end
  endtask

  // Receiver: checks accepted results and drives ready, with long holds.
  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready)
        sb.check_number(out_if.number_value, out_if.status);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= steady || ($urandom_range(99) >= 31);
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: errors");
    $finish;
  end

  // Main stimulus.
  initial begin
    stream_byte_t t;
    int           holds_done;
    holds_done = 0;
    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.data_byte    <= 8'h00;
    in_if.end_of_input <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every length form, each error and wrapping.
    send_item(8'd0, 1'b0);
    send_item(8'd250, 1'b0);
    send_item(BYTE_LEN1, 1'b0);
    send_item(8'hab, 1'b0);
    send_item(BYTE_LEN2, 1'b0);
    send_item(8'h34, 1'b0);
    send_item(8'h12, 1'b0);
    // Inverted four-byte form wraps to the largest positive value.
    send_item(BYTE_PREFIX, 1'b0);
    send_item(BYTE_LEN4, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(BYTE_PREFIX, 1'b0);
    send_item(8'd0, 1'b0);
    // Repeated prefix, then the unsupported eight-byte marker, bare and prefixed.
    send_item(BYTE_PREFIX, 1'b0);
    send_item(BYTE_PREFIX, 1'b0);
    send_item(BYTE_EIGHT, 1'b0);
    send_item(BYTE_PREFIX, 1'b0);
    send_item(BYTE_EIGHT, 1'b0);
    // End of input in each phase.
    send_item(8'hff, 1'b1);
    send_item(BYTE_PREFIX, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(BYTE_LEN2, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h5a, 1'b1);

    // Random numbers, errors and broken sequences.
    while (sent_count < ItemTarget) begin
      append_number();
      while (tx_q.size() != 0) begin
        t = tx_q.pop_front();
        send_item(t.data, t.eoi);
      end
      steady = (sent_count >= 450 && sent_count < 650);
      if ((holds_done == 0 && sent_count >= 300) || (holds_done == 1 && sent_count >= 800)) begin
        hold_req = 1'b1;
        holds_done++;
      end
    end
    in_if.valid <= 1'b0;

    // Drain, then leave room for anything stray.
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ----- prefix_coded_number_decoder_core.f -----
src/pcnd_pkg.sv
src/pcnd_if.sv
src/pcnd_front.sv
src/pcnd_queue.sv
src/pcnd_back.sv
src/prefix_coded_number_decoder_core.sv
verif/tb.sv
